// ===== sv/rhcc_pkg.sv =====
// Package for the RGB-to-HSV color classifier: widths, label and confidence codes.
// No dependencies; every module of the block imports it.
package rhcc_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int FULL = (1 << CHANNEL_BITS) - 1;
	// Hue numerator reaches 360*d, which is below 512*2^CHANNEL_BITS.
	localparam int HN_BITS = CHANNEL_BITS + 10;
	// Cross products: 100*channel or hue constant times d.
	localparam int PR_BITS = CHANNEL_BITS + 10;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = 1;

	typedef logic [3:0] label_t;
	typedef logic [1:0] conf_t;

	localparam label_t LBL_BLACK    = 4'd0;
	localparam label_t LBL_WHITE    = 4'd1;
	localparam label_t LBL_RED      = 4'd2;
	localparam label_t LBL_GREEN    = 4'd3;
	localparam label_t LBL_BLUE     = 4'd4;
	localparam label_t LBL_YELLOW   = 4'd5;
	localparam label_t LBL_LAVENDER = 4'd7;
	localparam label_t LBL_MAGENTA  = 4'd8;
	localparam label_t LBL_GRAY     = 4'd9;
	localparam label_t LBL_NONE     = 4'd10;

	localparam conf_t CONF_UNRELIABLE = 2'd0;
	localparam conf_t CONF_GOOD       = 2'd1;
	localparam conf_t CONF_CERTAIN    = 2'd2;

	// HSV as fractions: value = mx/FULL, sat = d/mx, hue = hn/d (gray: hue is -360).
	typedef struct packed {
		logic [CHANNEL_BITS-1:0] mx;
		logic [CHANNEL_BITS-1:0] d;
		logic [HN_BITS-1:0]      hn;
		logic                    gray;
	} hsv_t;

	typedef struct packed {
		label_t primary;
		label_t second;
		conf_t  conf;
	} result_t;

endpackage

// ===== sv/rhcc_front.sv =====
// Front end: accepts pixels and converts them to exact HSV fractions.
// Depends on rhcc_pkg.
module rhcc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rhcc_pkg::CHANNEL_BITS-1:0] red,
	input  logic [rhcc_pkg::CHANNEL_BITS-1:0] green,
	input  logic [rhcc_pkg::CHANNEL_BITS-1:0] blue,
	output logic                            hsv_valid,
	input  logic                            hsv_ready,
	output rhcc_pkg::hsv_t                  hsv
);
	import rhcc_pkg::*;

	logic [CHANNEL_BITS-1:0] mx, mn, d;
	logic [HN_BITS-1:0] hn;
	logic valid_s1;
	hsv_t hsv_s1;

	// Max, min and hue numerator per sextant.
	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		d = mx - mn;
		if (red == mx) begin
			if (green >= blue)
				hn = HN_BITS'(60 * ({{(HN_BITS-CHANNEL_BITS){1'b0}}, green - blue}));
			else
				hn = HN_BITS'(360 * {{(HN_BITS-CHANNEL_BITS){1'b0}}, d}) -
					HN_BITS'(60 * {{(HN_BITS-CHANNEL_BITS){1'b0}}, blue - green});
		end else if (green == mx) begin
			hn = HN_BITS'(60 * (2 * {{(HN_BITS-CHANNEL_BITS){1'b0}}, d} +
				{{(HN_BITS-CHANNEL_BITS){1'b0}}, blue} - {{(HN_BITS-CHANNEL_BITS){1'b0}}, red}));
		end else begin
			hn = HN_BITS'(60 * (4 * {{(HN_BITS-CHANNEL_BITS){1'b0}}, d} +
				{{(HN_BITS-CHANNEL_BITS){1'b0}}, red} - {{(HN_BITS-CHANNEL_BITS){1'b0}}, green}));
		end
	end

	assign in_ready = !valid_s1 || hsv_ready;

	// Single pipeline register toward the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hsv_s1 <= '{mx: mx, d: d, hn: hn, gray: (d == '0)};
		end
	end

	assign hsv_valid = valid_s1;
	assign hsv = hsv_s1;

endmodule

// ===== sv/rhcc_queue.sv =====
// Short queue between the HSV front end and the classifier back end.
// Depends on rhcc_pkg.
module rhcc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  rhcc_pkg::hsv_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output rhcc_pkg::hsv_t rd_data
);
	import rhcc_pkg::*;

	hsv_t mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [QPTR_BITS:0] count_q;
	logic push, pop;

	assign wr_ready = (count_q != (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_data;
	end

	// The fill count never exceeds the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH))
		else $error("queue overfilled");
	// A full queue refuses writes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == (QPTR_BITS+1)'(QUEUE_DEPTH)) |-> !wr_ready)
		else $error("full queue accepts");
	// A write without a read grows the count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("count did not grow");

endmodule

// ===== sv/rhcc_back.sv =====
// Back end: the decision tree on HSV fractions, with a registered result.
// Depends on rhcc_pkg.
module rhcc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hsv_valid,
	output logic              hsv_ready,
	input  rhcc_pkg::hsv_t    hsv,
	output logic              out_valid,
	input  logic              out_ready,
	output rhcc_pkg::result_t result
);
	import rhcc_pkg::*;

	logic [PR_BITS-1:0] v100, s100, mxp, dd;
	logic [HN_BITS-1:0] hn;
	logic valid_s1;
	result_t res_s1, r;

	assign v100 = PR_BITS'(100 * hsv.mx);
	assign s100 = PR_BITS'(100 * hsv.d);
	assign mxp = PR_BITS'(hsv.mx);
	assign dd = PR_BITS'(hsv.d);
	assign hn = hsv.hn;

	// Value compared with p/100 by cross-multiplying.
	function automatic logic vlt(input logic [PR_BITS-1:0] v, input int p);
		return v < PR_BITS'(p * FULL);
	endfunction
	function automatic logic vgt(input logic [PR_BITS-1:0] v, input int p);
		return v > PR_BITS'(p * FULL);
	endfunction

	// Hue compare; a gray pixel sits at -360, below every threshold.
	function automatic logic hlt(input logic g, input logic [HN_BITS-1:0] h,
		input logic [PR_BITS-1:0] dv, input int c);
		logic [PR_BITS+8:0] b;
		b = (PR_BITS+9)'(c) * (PR_BITS+9)'(dv);
		return g || ((PR_BITS+9)'(h) < b);
	endfunction
	function automatic logic hgt(input logic g, input logic [HN_BITS-1:0] h,
		input logic [PR_BITS-1:0] dv, input int c);
		logic [PR_BITS+8:0] b;
		b = (PR_BITS+9)'(c) * (PR_BITS+9)'(dv);
		return !g && ((PR_BITS+9)'(h) > b);
	endfunction

	// Saturation compares against p*mx; sat of black is 0 since d = 0 there.
	function automatic logic slt(input logic [PR_BITS-1:0] s,
		input logic [PR_BITS-1:0] m, input int p);
		logic [PR_BITS+7:0] b;
		b = (PR_BITS+8)'(p) * (PR_BITS+8)'(m);
		return (m == '0) ? (p > 0) : ((PR_BITS+8)'(s) < b);
	endfunction
	function automatic logic sgt(input logic [PR_BITS-1:0] s,
		input logic [PR_BITS-1:0] m, input int p);
		logic [PR_BITS+7:0] b;
		b = (PR_BITS+8)'(p) * (PR_BITS+8)'(m);
		return (m != '0) && ((PR_BITS+8)'(s) > b);
	endfunction

	// Decision tree.
	always_comb begin
		logic g, done;
		g = hsv.gray;
		done = 1'b0;
		r = '{primary: LBL_NONE, second: LBL_NONE, conf: CONF_CERTAIN};
		if (vlt(v100, 30)) begin
			if (sgt(s100, mxp, 30) && vgt(v100, 20)) begin
				r.second = LBL_BLACK;
				if (sgt(s100, mxp, 60) && !hlt(g, hn, dd, 65) && !hgt(g, hn, dd, 170)) begin
					r.primary = LBL_GREEN;
					done = 1'b1;
				end else if (sgt(s100, mxp, 80)) r.conf = CONF_UNRELIABLE;
				else r.conf = CONF_GOOD;
			end else begin
				r.primary = LBL_BLACK;
				done = 1'b1;
			end
		end else if ((vgt(v100, 80) && slt(s100, mxp, 20)) ||
			(vgt(v100, 70) && slt(s100, mxp, 10)) ||
			(vgt(v100, 60) && slt(s100, mxp, 5))) begin
			r.primary = LBL_WHITE;
			if (sgt(s100, mxp, 10)) begin
				r.conf = CONF_UNRELIABLE;
				r.primary = LBL_NONE;
				r.second = LBL_WHITE;
			end else begin
				if (vlt(v100, 70)) begin
					r.second = LBL_GRAY;
					r.conf = CONF_GOOD;
				end
				done = 1'b1;
			end
		end else if ((vlt(v100, 65) && slt(s100, mxp, 15)) ||
			(vlt(v100, 70) && slt(s100, mxp, 10)) ||
			(vlt(v100, 50) && slt(s100, mxp, 30) && hlt(g, hn, dd, 40) &&
			hgt(g, hn, dd, 10))) begin
			if (vlt(v100, 50)) begin
				r.primary = LBL_BLACK;
				r.conf = CONF_GOOD;
				if (vgt(v100, 40)) r.second = LBL_GRAY;
				done = 1'b1;
			end else if (slt(s100, mxp, 8)) begin
				r.conf = CONF_GOOD;
				r.primary = LBL_WHITE;
				r.second = LBL_GRAY;
				done = 1'b1;
			end else begin
				r.conf = CONF_UNRELIABLE;
				r.second = LBL_GRAY;
			end
		end

		if (!done) begin
			if (hlt(g, hn, dd, 30) || hgt(g, hn, dd, 330)) begin
				if (hgt(g, hn, dd, 10) && !hgt(g, hn, dd, 30) && slt(s100, mxp, 40)) begin
					if (hgt(g, hn, dd, 20)) begin
						r.primary = LBL_YELLOW;
						r.conf = CONF_GOOD;
					end else begin
						r.primary = LBL_RED;
						r.conf = CONF_UNRELIABLE;
					end
					if (vlt(v100, 70)) r.second = LBL_GRAY;
				end else begin
					r.primary = LBL_RED;
					if (((slt(s100, mxp, 30) && vlt(v100, 60)) ||
						(slt(s100, mxp, 40) && vlt(v100, 35))) && r.conf == CONF_CERTAIN)
						r.conf = CONF_GOOD;
				end
			end else if (hgt(g, hn, dd, 80) && hlt(g, hn, dd, 170)) begin
				r.primary = LBL_GREEN;
				if (slt(s100, mxp, 20) && r.conf == CONF_CERTAIN) r.conf = CONF_GOOD;
				if (hgt(g, hn, dd, 160) && (slt(s100, mxp, 60) || vgt(v100, 60))) begin
					r.conf = CONF_UNRELIABLE;
					r.second = LBL_BLUE;
				end
			end else if (hgt(g, hn, dd, 185) && hlt(g, hn, dd, 270)) begin
				if (slt(s100, mxp, 30)) begin
					if (r.conf == CONF_CERTAIN) r.conf = CONF_GOOD;
					if (vgt(v100, 75)) begin
						r.primary = LBL_WHITE;
						r.second = LBL_BLUE;
					end else begin
						r.primary = LBL_BLUE;
						r.second = vlt(v100, 60) ? LBL_GRAY : LBL_WHITE;
					end
				end else begin
					r.primary = LBL_BLUE;
				end
			end else begin
				if (slt(s100, mxp, 50)) r.conf = CONF_UNRELIABLE;
				if (!hlt(g, hn, dd, 30) && !hgt(g, hn, dd, 80)) begin
					r.primary = (!hlt(g, hn, dd, 70) && !vgt(v100, 70)) ? LBL_GREEN : LBL_YELLOW;
				end else begin
					if (r.conf == CONF_CERTAIN) r.conf = CONF_GOOD;
					if (!hlt(g, hn, dd, 150) && !hgt(g, hn, dd, 185)) begin
						if (!hlt(g, hn, dd, 180)) r.primary = LBL_BLUE;
						else if (hlt(g, hn, dd, 170)) begin
							r.primary = LBL_GREEN;
							r.second = LBL_BLUE;
						end else begin
							r.primary = LBL_BLUE;
							r.second = LBL_GREEN;
						end
					end else if (!hlt(g, hn, dd, 270) && !hgt(g, hn, dd, 330)) begin
						if (hlt(g, hn, dd, 280)) begin
							r.primary = LBL_BLUE;
							if (r.second == LBL_NONE) r.second = LBL_LAVENDER;
						end else begin
							r.primary = LBL_RED;
							if (r.second == LBL_NONE) r.second = LBL_MAGENTA;
						end
					end
				end
			end
		end
	end

	assign hsv_ready = !valid_s1 || out_ready;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hsv_ready) begin
			valid_s1 <= hsv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hsv_ready && hsv_valid) res_s1 <= r;
	end

	assign out_valid = valid_s1;
	assign result = res_s1;

endmodule

// ===== sv/rgb_hsv_color_classifier_unit.sv =====
// RGB pixel color classifier: HSV front end, two-entry queue, decision-tree back end.
// Registers from acceptance to result: front-end register, queue entry, back-end output register.
// Throughput: one pixel per cycle while m_tready is high; a low m_tready stalls the pipeline.
// Reset: arst_n clears all valid flags, queue pointers and the fill count; data registers are not reset.
// Depends on rhcc_pkg, rhcc_front, rhcc_queue and rhcc_back.
module rgb_hsv_color_classifier_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red_level[7:0], green_level[15:8], blue_level[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // primary_label[3:0], second_label[7:4], confidence[9:8]
);
	import rhcc_pkg::*;

	logic f_valid, f_ready, q_valid, q_ready;
	hsv_t f_hsv, q_hsv;
	result_t res;

	rhcc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.red(s_tdata[7:0]), .green(s_tdata[15:8]), .blue(s_tdata[23:16]),
		.hsv_valid(f_valid), .hsv_ready(f_ready), .hsv(f_hsv)
	);

	rhcc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_hsv), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_hsv)
	);

	rhcc_back u_back (
		.clk(clk), .arst_n(arst_n), .hsv_valid(q_valid), .hsv_ready(q_ready),
		.hsv(q_hsv), .out_valid(m_tvalid), .out_ready(m_tready), .result(res)
	);

	assign m_tdata = {6'd0, res.conf, res.second, res.primary};

endmodule

// ===== verif/rgb_hsv_color_classifier_unit_tb.sv =====
// Testbench for the RGB-to-HSV color classifier: random and directed pixels, random stalls.
// Predicts each label and confidence from exact fraction tests; depends on rhcc_pkg and the RTL.
module rgb_hsv_color_classifier_unit_tb;
	import rhcc_pkg::*;

	typedef struct packed {
		label_t primary;
		label_t second;
		conf_t  conf;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	logic [23:0] pixel_queue[$];
	verdict_t    verdict_queue[$];
	int          error_count;
	int          cycle_count;
	int          send_gap;
	int          recv_gap;
	bit          quiet_tail;
	bit          hold_send;

	rgb_hsv_color_classifier_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Exact HSV fractions: value = vn/FULL, saturation = sn/sd, hue = hn/hd.
	longint vn, sn, sd, hn, hd;

	function automatic int fcmp(longint n, longint d, longint p, longint q);
		longint a = n * q;
		longint b = p * d;
		return (a > b) ? 1 : ((a < b) ? -1 : 0);
	endfunction

	function automatic bit v_lt(int p); return fcmp(vn, FULL, p, 100) < 0; endfunction
	function automatic bit v_le(int p); return fcmp(vn, FULL, p, 100) <= 0; endfunction
	function automatic bit v_gt(int p); return fcmp(vn, FULL, p, 100) > 0; endfunction
	function automatic bit s_lt(int p); return fcmp(sn, sd, p, 100) < 0; endfunction
	function automatic bit s_gt(int p); return fcmp(sn, sd, p, 100) > 0; endfunction
	function automatic bit h_lt(int c); return hn < c * hd; endfunction
	function automatic bit h_le(int c); return hn <= c * hd; endfunction
	function automatic bit h_gt(int c); return hn > c * hd; endfunction
	function automatic bit h_ge(int c); return hn >= c * hd; endfunction

	// Decision tree on one pixel; mirrors the early exits with a done flag.
	function automatic verdict_t classify_pixel(logic [23:0] px);
		longint r, g, b, mx, mn, d;
		verdict_t v;
		bit done;
		r = px[7:0];
		g = px[15:8];
		b = px[23:16];
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		vn = mx;
		if (mx > 0) begin
			sn = d; sd = mx;
		end else begin
			sn = 0; sd = 1;
		end
		if (d == 0) begin
			hn = -360; hd = 1;
		end else begin
			hd = d;
			if (r == mx) begin
				hn = 60 * (g - b);
				if (hn < 0) hn += 360 * d;
			end else if (g == mx) begin
				hn = 60 * (2 * d + b - r);
			end else begin
				hn = 60 * (4 * d + r - g);
			end
		end
		v.conf = CONF_CERTAIN;
		v.primary = LBL_NONE;
		v.second = LBL_NONE;
		done = 0;
		// Brightness and saturation screen first.
		if (v_lt(30)) begin
			if (s_gt(30) && v_gt(20)) begin
				v.second = LBL_BLACK;
				if (s_gt(60) && h_ge(65) && h_le(170)) begin
					v.primary = LBL_GREEN; done = 1;
				end else if (s_gt(80)) v.conf = CONF_UNRELIABLE;
				else v.conf = CONF_GOOD;
			end else begin
				v.primary = LBL_BLACK; done = 1;
			end
		end else if ((v_gt(80) && s_lt(20)) || (v_gt(70) && s_lt(10)) ||
		             (v_gt(60) && s_lt(5))) begin
			v.primary = LBL_WHITE;
			if (s_gt(10)) begin
				v.conf = CONF_UNRELIABLE; v.primary = LBL_NONE; v.second = LBL_WHITE;
			end else begin
				if (v_lt(70)) begin
					v.second = LBL_GRAY; v.conf = CONF_GOOD;
				end
				done = 1;
			end
		end else if ((v_lt(65) && s_lt(15)) || (v_lt(70) && s_lt(10)) ||
		             (v_lt(50) && s_lt(30) && h_lt(40) && h_gt(10))) begin
			if (v_lt(50)) begin
				v.primary = LBL_BLACK; v.conf = CONF_GOOD;
				if (v_gt(40)) v.second = LBL_GRAY;
				done = 1;
			end else if (s_lt(8)) begin
				v.conf = CONF_GOOD; v.primary = LBL_WHITE; v.second = LBL_GRAY; done = 1;
			end else begin
				v.conf = CONF_UNRELIABLE; v.second = LBL_GRAY;
			end
		end
		if (done) return v;
		// Hue sectors.
		if (h_lt(30) || h_gt(330)) begin
			if (h_gt(10) && h_le(30) && s_lt(40)) begin
				if (h_gt(20)) begin
					v.primary = LBL_YELLOW; v.conf = CONF_GOOD;
				end else begin
					v.primary = LBL_RED; v.conf = CONF_UNRELIABLE;
				end
				if (v_lt(70)) v.second = LBL_GRAY;
			end else begin
				v.primary = LBL_RED;
				if (((s_lt(30) && v_lt(60)) || (s_lt(40) && v_lt(35))) &&
				    v.conf == CONF_CERTAIN) v.conf = CONF_GOOD;
			end
		end else if (h_gt(80) && h_lt(170)) begin
			v.primary = LBL_GREEN;
			if (s_lt(20) && v.conf == CONF_CERTAIN) v.conf = CONF_GOOD;
			if (h_gt(160) && (s_lt(60) || v_gt(60))) begin
				v.conf = CONF_UNRELIABLE; v.second = LBL_BLUE;
			end
		end else if (h_gt(185) && h_lt(270)) begin
			if (s_lt(30)) begin
				if (v.conf == CONF_CERTAIN) v.conf = CONF_GOOD;
				if (v_gt(75)) begin
					v.primary = LBL_WHITE; v.second = LBL_BLUE;
				end else begin
					v.primary = LBL_BLUE;
					v.second = v_lt(60) ? LBL_GRAY : LBL_WHITE;
				end
			end else v.primary = LBL_BLUE;
		end else begin
			if (s_lt(50)) v.conf = CONF_UNRELIABLE;
			if (h_ge(30) && h_le(80)) begin
				v.primary = (h_ge(70) && v_le(70)) ? LBL_GREEN : LBL_YELLOW;
			end else begin
				if (v.conf == CONF_CERTAIN) v.conf = CONF_GOOD;
				if (h_ge(150) && h_le(185)) begin
					if (h_ge(180)) v.primary = LBL_BLUE;
					else if (h_lt(170)) begin
						v.primary = LBL_GREEN; v.second = LBL_BLUE;
					end else begin
						v.primary = LBL_BLUE; v.second = LBL_GREEN;
					end
				end else if (h_ge(270) && h_le(330)) begin
					if (h_lt(280)) begin
						v.primary = LBL_BLUE;
						if (v.second == LBL_NONE) v.second = LBL_LAVENDER;
					end else begin
						v.primary = LBL_RED;
						if (v.second == LBL_NONE) v.second = LBL_MAGENTA;
					end
				end
			end
		end
		return v;
	endfunction

	function automatic logic [23:0] rgb(int r, int g, int b);
		return {b[7:0], g[7:0], r[7:0]};
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Driver: presents queued pixels, with random idle bursts and one drain pause.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				verdict_queue.push_back(classify_pixel(s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 0;
				end else if (hold_send || pixel_queue.size() == 0) begin
					s_tvalid <= 0;
				end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 14);
					s_tvalid <= 0;
				end else begin
					s_tdata <= pixel_queue.pop_front();
					s_tvalid <= 1;
				end
			end
		end
	end

	// Monitor: checks each accepted item against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			m_tready <= 0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_queue.size() == 0) begin
					$error("result with no pending pixel: %h", m_tdata);
					error_count++;
				end else begin
					want = verdict_queue.pop_front();
					if (m_tdata[3:0] !== want.primary) begin
						$error("primary_label expected %0d actual %0d", want.primary, m_tdata[3:0]);
						error_count++;
					end
					if (m_tdata[7:4] !== want.second) begin
						$error("second_label expected %0d actual %0d", want.second, m_tdata[7:4]);
						error_count++;
					end
					if (m_tdata[9:8] !== want.conf) begin
						$error("confidence expected %0d actual %0d", want.conf, m_tdata[9:8]);
						error_count++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 0;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(0, 14);
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int r, g, b, k;
		error_count = 0;
		cycle_count = 0;
		quiet_tail = 0;
		hold_send = 0;
		arst_n = 0;
		// Directed pixels: extremes, black, gray, channel ties and each hue region.
		pixel_queue.push_back(rgb(0, 0, 0));
		pixel_queue.push_back(rgb(255, 255, 255));
		pixel_queue.push_back(rgb(128, 128, 128));
		pixel_queue.push_back(rgb(255, 0, 0));
		pixel_queue.push_back(rgb(0, 255, 0));
		pixel_queue.push_back(rgb(0, 0, 255));
		pixel_queue.push_back(rgb(255, 255, 0));
		pixel_queue.push_back(rgb(0, 255, 255));
		pixel_queue.push_back(rgb(255, 0, 255));
		pixel_queue.push_back(rgb(255, 255, 128));
		pixel_queue.push_back(rgb(128, 255, 255));
		pixel_queue.push_back(rgb(255, 128, 255));
		pixel_queue.push_back(rgb(60, 70, 60));
		pixel_queue.push_back(rgb(200, 120, 100));
		pixel_queue.push_back(rgb(130, 120, 115));
		pixel_queue.push_back(rgb(200, 210, 240));
		pixel_queue.push_back(rgb(100, 120, 160));
		pixel_queue.push_back(rgb(150, 60, 255));
		pixel_queue.push_back(rgb(255, 60, 200));
		pixel_queue.push_back(rgb(20, 200, 160));
		pixel_queue.push_back(rgb(40, 255, 200));
		pixel_queue.push_back(rgb(180, 255, 40));
		pixel_queue.push_back(rgb(70, 40, 50));
		pixel_queue.push_back(rgb(1, 0, 0));
		repeat (3) @(posedge clk);
		arst_n <= 1;
		// Hold the sender once until everything directed has come back.
		wait (pixel_queue.size() == 0 && !s_tvalid);
		hold_send = 1;
		wait (verdict_queue.size() == 0);
		hold_send = 0;
		for (k = 0; k < 400; k++) begin
			case ($urandom_range(0, 3))
				0: pixel_queue.push_back(24'($urandom));
				1: begin
					// Near-gray pixels exercise the low-saturation branches.
					r = $urandom_range(0, 255);
					g = r + $urandom_range(0, 20) - 10;
					b = r + $urandom_range(0, 20) - 10;
					if (g < 0) g = 0;
					if (g > 255) g = 255;
					if (b < 0) b = 0;
					if (b > 255) b = 255;
					pixel_queue.push_back(rgb(r, g, b));
				end
				2: begin
					// Dark pixels.
					pixel_queue.push_back(rgb($urandom_range(0, 90), $urandom_range(0, 90),
					                          $urandom_range(0, 90)));
				end
				default: begin
					// Two channels tied as the maximum.
					r = $urandom_range(0, 255);
					g = $urandom_range(0, r);
					case ($urandom_range(0, 2))
						0: pixel_queue.push_back(rgb(r, r, g));
						1: pixel_queue.push_back(rgb(r, g, r));
						default: pixel_queue.push_back(rgb(g, r, r));
					endcase
				end
			endcase
			if (k == 300) wait (pixel_queue.size() < 20);
		end
		wait (pixel_queue.size() < 60);
		quiet_tail = 1;
		wait (pixel_queue.size() == 0 && !s_tvalid);
		wait (verdict_queue.size() == 0);
		repeat (10) @(posedge clk);
		if (error_count == 0 && verdict_queue.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
